// ===== design/image_rotate_nearest_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the image rotation block
// Shared property forms, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_NEAREST_ASSERT_SVH
`define IMAGE_ROTATE_NEAREST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IROT_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IROT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/irot_pkg.sv =====
// ----------------------------------------------------------------------------
// irot_pkg
// Types, widths and codes shared by the image rotation block.
// ----------------------------------------------------------------------------
package irot_pkg;

	localparam int DIM_W        = 10;
	localparam int DEST_W       = 11;
	localparam int TRIG_W       = 16;
	localparam int CH_W         = 3;
	localparam int PIX_W        = 32;
	localparam int TRIG_FRAC    = 14;
	localparam int SAMPLE_SHIFT = TRIG_FRAC + 1;
	localparam int AREA_W       = 2 * DIM_W;
	localparam int DELTA_W      = DEST_W + 2;
	localparam int PROD_W       = DELTA_W + TRIG_W;
	localparam int COORD_W      = PROD_W + 1;
	localparam int RESET_DIM    = 512;

	localparam int DEF_MAX_SRC_WIDTH  = 512;
	localparam int DEF_MAX_SRC_HEIGHT = 512;
	localparam int DEF_DEPTH          = DEF_MAX_SRC_WIDTH * DEF_MAX_SRC_HEIGHT;
	localparam int DEF_ADDR_W         = $clog2(DEF_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_COS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_SIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	localparam logic [CH_W-1:0]         CH_RGBA  = 3'd4;
	localparam logic [PIX_W-1:0]        RGB_MASK = 32'h00FF_FFFF;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

	typedef struct packed {
		logic             opcode;
		logic [PIX_W-1:0] pixel_in;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [DIM_W-1:0] out_x;
		logic [DIM_W-1:0] out_y;
		logic             covered;
		logic             frame_last;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0]         src_width;
		logic [DIM_W-1:0]         src_height;
		logic signed [TRIG_W-1:0] rotation_cos;
		logic signed [TRIG_W-1:0] rotation_sin;
		logic                     alpha_en;
	} cfg_t;

	typedef struct packed {
		logic [DEST_W-1:0] dest_width;
		logic [DEST_W-1:0] dest_height;
		logic [AREA_W-1:0] area;
	} dims_t;

	typedef struct packed {
		logic             emit;
		logic [DIM_W-1:0] out_x;
		logic [DIM_W-1:0] out_y;
		logic             last;
		logic             covered;
	} meta_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mreq_t;

endpackage

// ===== design/image_rotate_nearest.sv =====
// ----------------------------------------------------------------------------
// image_rotate_nearest
// Rotates an image about its center by inverse mapping with truncating
// nearest-neighbor sampling, one pixel word per command.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                      Taken at the edge when
// command   start, busy, cmd                             start && !busy
// result    result_valid, result                         result_valid (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// A command word is taken every cycle while busy is low; the mapping pipeline
// and the single store port each handle one word per cycle.
// An emit word gives its result word through the map stages, the store read
// register and the result register; a load word writes the frame store from the last map stage.
// After reset and after each register write, busy and !cfg_ready stand
// while the size unit forms the output frame size (products, then round).
// The frame store is not cleared; a pixel read before it was loaded is undefined.
// The receiver cannot stall, so the pipeline never holds and results never queue.
//
// Load words fill the store in raster order and wrap after the last source
// pixel. Emit words walk the output frame in raster order. Each output pixel
// is mapped back with the rotation; the Q15 source coordinate is floored to
// pick the source pixel, and a pixel that falls outside the source is zero.
// Alpha is copied only with four channels configured.
// ----------------------------------------------------------------------------
`include "image_rotate_nearest_assert.svh"

module image_rotate_nearest #(
	parameter int MAX_SRC_WIDTH  = irot_pkg::DEF_MAX_SRC_WIDTH,
	parameter int MAX_SRC_HEIGHT = irot_pkg::DEF_MAX_SRC_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  irot_pkg::cmd_t                    cmd,
	output logic                              result_valid,
	output irot_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irot_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irot_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (ADDR_W + 1 > irot_pkg::AREA_W) ? ADDR_W + 1 : irot_pkg::AREA_W;
	localparam int RST_W  = (MAX_SRC_WIDTH < irot_pkg::RESET_DIM) ?
		MAX_SRC_WIDTH : irot_pkg::RESET_DIM;
	localparam int RST_H  = (MAX_SRC_HEIGHT < irot_pkg::RESET_DIM) ?
		MAX_SRC_HEIGHT : irot_pkg::RESET_DIM;

	localparam int DEST_W = irot_pkg::DEST_W;
	localparam int DIM_W  = irot_pkg::DIM_W;

	// Width and height saturate to 1..max.
	function automatic logic [DIM_W-1:0] clamp_dim(
		input logic [DIM_W-1:0] v,
		input int               maxv
	);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (int'(v) > maxv) begin
			return DIM_W'(maxv);
		end
		return v;
	endfunction

	// Sine and cosine saturate to plus or minus one.
	function automatic logic signed [irot_pkg::TRIG_W-1:0] clamp_trig(
		input logic signed [irot_pkg::TRIG_W-1:0] t
	);
		if (t > irot_pkg::TRIG_ONE) begin
			return irot_pkg::TRIG_ONE;
		end
		if (t < -irot_pkg::TRIG_ONE) begin
			return -irot_pkg::TRIG_ONE;
		end
		return t;
	endfunction

	irot_pkg::cfg_t    cfg_q;
	irot_pkg::dims_t   dims;
	irot_pkg::meta_t   meta_in, map_meta, meta_s6;
	irot_pkg::mreq_t   mreq;
	irot_pkg::result_t result_q;

	logic                       sz_busy;
	logic                       cfg_wr, cfg_hit;
	logic                       accept;
	logic [DEST_W-1:0]          x_q, y_q, x_inc, y_inc;
	logic                       wrap_x, wrap_y;
	logic [ADDR_W-1:0]          la_q;
	logic [CMP_W-1:0]           la_inc;
	logic                       la_wrap;
	logic [ADDR_W-1:0]          st_addr;
	logic [irot_pkg::PIX_W-1:0] st_wdata, rd_data, px_out;
	logic                       map_vld, v_s6;
	logic                       result_valid_q;

	// ------------------------------------------------------------------
	// Configuration registers. A write to a known register restarts the
	// size unit and rewinds both the raster walk and the load address.
	// ------------------------------------------------------------------
	assign cfg_ready = !sz_busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			irot_pkg::REG_SRC_WIDTH,
			irot_pkg::REG_SRC_HEIGHT,
			irot_pkg::REG_ROTATION_COS,
			irot_pkg::REG_ROTATION_SIN,
			irot_pkg::REG_CHANNEL_COUNT: cfg_hit = cfg_wr;
			default:                     cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width    <= DIM_W'(RST_W);
			cfg_q.src_height   <= DIM_W'(RST_H);
			cfg_q.rotation_cos <= irot_pkg::TRIG_ONE;
			cfg_q.rotation_sin <= '0;
			cfg_q.alpha_en     <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_index)
				irot_pkg::REG_SRC_WIDTH:
					cfg_q.src_width <= clamp_dim(cfg_data[DIM_W-1:0], MAX_SRC_WIDTH);
				irot_pkg::REG_SRC_HEIGHT:
					cfg_q.src_height <= clamp_dim(cfg_data[DIM_W-1:0], MAX_SRC_HEIGHT);
				irot_pkg::REG_ROTATION_COS:
					cfg_q.rotation_cos <= clamp_trig($signed(cfg_data));
				irot_pkg::REG_ROTATION_SIN:
					cfg_q.rotation_sin <= clamp_trig($signed(cfg_data));
				irot_pkg::REG_CHANNEL_COUNT:
					cfg_q.alpha_en <= (cfg_data[irot_pkg::CH_W-1:0] == irot_pkg::CH_RGBA);
				default: ;
			endcase
		end
	end

	irot_size u_size (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cfg_hit),
		.cfg    (cfg_q),
		.busy   (sz_busy),
		.dims   (dims)
	);

	// ------------------------------------------------------------------
	// Command side: raster walk for emits, fill pointer for loads.
	// ------------------------------------------------------------------
	assign busy   = sz_busy;
	assign accept = start && !busy;

	assign x_inc   = x_q + DEST_W'(1);
	assign y_inc   = y_q + DEST_W'(1);
	assign wrap_x  = (x_inc >= dims.dest_width);
	assign wrap_y  = (y_inc >= dims.dest_height);
	assign la_inc  = CMP_W'(la_q) + CMP_W'(1);
	assign la_wrap = (la_inc >= CMP_W'(dims.area));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			la_q <= '0;
		end else if (cfg_hit) begin
			x_q  <= '0;
			y_q  <= '0;
			la_q <= '0;
		end else if (accept) begin
			if (cmd.opcode == irot_pkg::OP_EMIT) begin
				if (wrap_x) begin
					x_q <= '0;
					y_q <= wrap_y ? '0 : y_inc;
				end else begin
					x_q <= x_inc;
				end
			end else begin
				la_q <= la_wrap ? '0 : ADDR_W'(la_inc);
			end
		end
	end

	assign meta_in.emit    = (cmd.opcode == irot_pkg::OP_EMIT);
	assign meta_in.out_x   = x_q[DIM_W-1:0];
	assign meta_in.out_y   = y_q[DIM_W-1:0];
	assign meta_in.last    = wrap_x && wrap_y;
	assign meta_in.covered = 1'b0;

	irot_map #(
		.ADDR_W (ADDR_W)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (accept),
		.meta_in   (meta_in),
		.x         (x_q),
		.y         (y_q),
		.pixel     (cmd.pixel_in),
		.load_addr (la_q),
		.cfg       (cfg_q),
		.dims      (dims),
		.mreq      (mreq),
		.addr      (st_addr),
		.wdata     (st_wdata),
		.meta_out  (map_meta),
		.meta_vld  (map_vld)
	);

	irot_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.req   (mreq),
		.addr  (st_addr),
		.wdata (st_wdata),
		.rdata (rd_data)
	);

	// ------------------------------------------------------------------
	// Result side. Pixel tags wait in meta_s6 beside the store read, then
	// the result word is formed and registered for its single cycle.
	// ------------------------------------------------------------------
	always_comb begin
		if (!meta_s6.covered) begin
			px_out = '0;
		end else if (cfg_q.alpha_en) begin
			px_out = rd_data;
		end else begin
			px_out = rd_data & irot_pkg::RGB_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s6           <= map_vld;
			result_valid_q <= v_s6 && meta_s6.emit;
		end
	end

	always_ff @(posedge clk) begin
		meta_s6             <= map_meta;
		result_q.pixel_out  <= px_out;
		result_q.out_x      <= meta_s6.out_x;
		result_q.out_y      <= meta_s6.out_y;
		result_q.covered    <= meta_s6.covered;
		result_q.frame_last <= meta_s6.last;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`IROT_ASSERT_HOLDS(a_result_from_emit, result_valid,
		$past(start && !busy && (cmd.opcode == irot_pkg::OP_EMIT), 7),
		"result word without an emit word seven cycles earlier")
	`IROT_ASSERT_HOLDS(a_uncovered_zero, result_valid && !result.covered,
		result.pixel_out == '0, "uncovered pixel is not zero")
	`IROT_ASSERT_HOLDS(a_raster_in_frame, !busy,
		(x_q < dims.dest_width) && (y_q < dims.dest_height),
		"raster position outside the output frame")
	`IROT_ASSERT_HOLDS(a_load_in_frame, !busy,
		CMP_W'(la_q) < CMP_W'(dims.area), "load address outside the source frame")
	`IROT_ASSERT_NEXT(a_cfg_recompute,
		cfg_valid && cfg_ready && (cfg_index <= irot_pkg::REG_CHANNEL_COUNT),
		busy, "register write did not restart the size unit")

endmodule

// ===== design/irot_size.sv =====
// ----------------------------------------------------------------------------
// irot_size
// Output frame size unit: bounding box of the rotated source, two stages.
// ----------------------------------------------------------------------------
module irot_size (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  irot_pkg::cfg_t  cfg,
	output logic            busy,
	output irot_pkg::dims_t dims
);

	localparam int MAGP_W = irot_pkg::DIM_W + irot_pkg::TRIG_W - 1;
	localparam int SUM_W  = MAGP_W + 1;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (irot_pkg::TRIG_FRAC - 1);

	function automatic logic [irot_pkg::TRIG_W-2:0] trig_mag(
		input logic signed [irot_pkg::TRIG_W-1:0] t
	);
		logic [irot_pkg::TRIG_W-1:0] m;
		m = t[irot_pkg::TRIG_W-1] ? -t : t;
		return m[irot_pkg::TRIG_W-2:0];
	endfunction

	function automatic logic [irot_pkg::DEST_W-1:0] round_size(
		input logic [MAGP_W-1:0] a,
		input logic [MAGP_W-1:0] b
	);
		logic [SUM_W-1:0]            s;
		logic [irot_pkg::DEST_W-1:0] r;
		s = SUM_W'(a) + SUM_W'(b) + HALF;
		r = irot_pkg::DEST_W'(s >> irot_pkg::TRIG_FRAC);
		return (r == '0) ? irot_pkg::DEST_W'(1) : r;
	endfunction

	logic go_q;
	logic v_s1;
	logic [MAGP_W-1:0]           wc_s1, hs_s1, ws_s1, hc_s1;
	logic [irot_pkg::AREA_W-1:0] area_s1;
	logic [irot_pkg::TRIG_W-2:0] ac, as;
	irot_pkg::dims_t             dims_q;

	assign ac = trig_mag(cfg.rotation_cos);
	assign as = trig_mag(cfg.rotation_sin);

	// go_q comes out of reset set so the reset registers get their sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b1;
			v_s1 <= 1'b0;
		end else begin
			go_q <= go;
			v_s1 <= go_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go_q) begin
			wc_s1   <= MAGP_W'(cfg.src_width) * MAGP_W'(ac);
			hs_s1   <= MAGP_W'(cfg.src_height) * MAGP_W'(as);
			ws_s1   <= MAGP_W'(cfg.src_width) * MAGP_W'(as);
			hc_s1   <= MAGP_W'(cfg.src_height) * MAGP_W'(ac);
			area_s1 <= irot_pkg::AREA_W'(cfg.src_width) * irot_pkg::AREA_W'(cfg.src_height);
		end
		if (v_s1) begin
			dims_q.dest_width  <= round_size(wc_s1, hs_s1);
			dims_q.dest_height <= round_size(ws_s1, hc_s1);
			dims_q.area        <= area_s1;
		end
	end

	assign busy = go_q | v_s1;
	assign dims = dims_q;

endmodule

// ===== design/irot_map.sv =====
// ----------------------------------------------------------------------------
// irot_map
// Inverse mapping pipeline: output pixel to source address, five stages.
// Loads ride the same stages so every store access keeps command order.
// ----------------------------------------------------------------------------
module irot_map #(
	parameter int ADDR_W = irot_pkg::DEF_ADDR_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  irot_pkg::meta_t               meta_in,
	input  logic [irot_pkg::DEST_W-1:0]   x,
	input  logic [irot_pkg::DEST_W-1:0]   y,
	input  logic [irot_pkg::PIX_W-1:0]    pixel,
	input  logic [ADDR_W-1:0]             load_addr,
	input  irot_pkg::cfg_t                cfg,
	input  irot_pkg::dims_t               dims,
	output irot_pkg::mreq_t               mreq,
	output logic [ADDR_W-1:0]             addr,
	output logic [irot_pkg::PIX_W-1:0]    wdata,
	output irot_pkg::meta_t               meta_out,
	output logic                          meta_vld
);

	localparam int DW    = irot_pkg::DELTA_W;
	localparam int PW    = irot_pkg::PROD_W;
	localparam int CW    = irot_pkg::COORD_W;
	localparam int SS    = irot_pkg::SAMPLE_SHIFT;
	localparam int INT_W = CW - 1 - SS;
	localparam int AW    = irot_pkg::AREA_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	irot_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [irot_pkg::PIX_W-1:0] pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic [ADDR_W-1:0]          la_s1, la_s2, la_s3, la_s4, addr_s5;
	logic signed [DW-1:0]       dx_c, dy_c, dx_s1, dy_s1;
	logic signed [PW-1:0]       pxc_s2, pys_s2, pxs_s2, pyc_s2;
	logic signed [CW-1:0]       offx_c, offy_c, vx_s3, vy_s3;
	logic                       covx_c, covy_c, cov_s4;
	logic [irot_pkg::DIM_W-1:0] ix_s4, iy_s4;
	irot_pkg::mreq_t            mreq_s5;

	// Centered, doubled coordinates: 2x - Dw and 2y - Dh.
	assign dx_c = $signed({1'b0, x, 1'b0}) - $signed({2'b00, dims.dest_width});
	assign dy_c = $signed({1'b0, y, 1'b0}) - $signed({2'b00, dims.dest_height});

	assign offx_c = $signed(CW'({cfg.src_width, {irot_pkg::TRIG_FRAC{1'b0}}}));
	assign offy_c = $signed(CW'({cfg.src_height, {irot_pkg::TRIG_FRAC{1'b0}}}));

	// The source coordinate is in Q15; its integer part is the sample index.
	assign covx_c = !vx_s3[CW-1] && (vx_s3[CW-2:SS] < INT_W'(cfg.src_width));
	assign covy_c = !vy_s3[CW-1] && (vy_s3[CW-2:SS] < INT_W'(cfg.src_height));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			mreq_s5 <= '0;
		end else begin
			v_s1       <= acc;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			mreq_s5.wr <= v_s4 && !meta_s4.emit;
			mreq_s5.rd <= v_s4 && meta_s4.emit && cov_s4;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= meta_in;
		dx_s1   <= dx_c;
		dy_s1   <= dy_c;
		pix_s1  <= pixel;
		la_s1   <= load_addr;

		meta_s2 <= meta_s1;
		pxc_s2  <= PW'(dx_s1) * PW'(cfg.rotation_cos);
		pys_s2  <= PW'(dy_s1) * PW'(cfg.rotation_sin);
		pxs_s2  <= PW'(dx_s1) * PW'(cfg.rotation_sin);
		pyc_s2  <= PW'(dy_s1) * PW'(cfg.rotation_cos);
		pix_s2  <= pix_s1;
		la_s2   <= la_s1;

		meta_s3 <= meta_s2;
		vx_s3   <= CW'(pxc_s2) + CW'(pys_s2) + offx_c;
		vy_s3   <= CW'(pyc_s2) - CW'(pxs_s2) + offy_c;
		pix_s3  <= pix_s2;
		la_s3   <= la_s2;

		meta_s4 <= meta_s3;
		cov_s4  <= covx_c && covy_c;
		ix_s4   <= vx_s3[SS +: irot_pkg::DIM_W];
		iy_s4   <= vy_s3[SS +: irot_pkg::DIM_W];
		pix_s4  <= pix_s3;
		la_s4   <= la_s3;

		// The coverage found in stage four replaces the incoming flag.
		meta_s5 <= {meta_s4.emit, meta_s4.out_x, meta_s4.out_y, meta_s4.last, cov_s4};
		pix_s5  <= pix_s4;
		if (meta_s4.emit) begin
			addr_s5 <= ADDR_W'(AW'(iy_s4) * AW'(cfg.src_width) + AW'(ix_s4));
		end else begin
			addr_s5 <= la_s4;
		end
	end

	assign mreq     = mreq_s5;
	assign addr     = addr_s5;
	assign wdata    = pix_s5;
	assign meta_out = meta_s5;
	assign meta_vld = v_s5;

endmodule

// ===== design/irot_store.sv =====
// ----------------------------------------------------------------------------
// irot_store
// Source frame store: one port, write or registered read each cycle.
// ----------------------------------------------------------------------------
module irot_store #(
	parameter int DEPTH  = irot_pkg::DEF_DEPTH,
	parameter int ADDR_W = irot_pkg::DEF_ADDR_W
) (
	input  logic                       clk,
	input  irot_pkg::mreq_t            req,
	input  logic [ADDR_W-1:0]          addr,
	input  logic [irot_pkg::PIX_W-1:0] wdata,
	output logic [irot_pkg::PIX_W-1:0] rdata
);

	logic [irot_pkg::PIX_W-1:0] mem [DEPTH];
	logic [irot_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[addr] <= wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
